// ===== rtl/tnd_pkg.sv =====
// ----------------------------------------------------------------------------
// tnd_pkg
// Shared constants, note ratio table and control types of the note tuner.
// ----------------------------------------------------------------------------
package tnd_pkg;

    localparam int NUM_NOTES       = 88;
    localparam int RATIO_FRAC_BITS = 20;
    localparam int SEMI_FRAC_BITS  = 32;
    localparam int REF_OCTAVES     = 4;

    localparam int IN_W       = 24;
    localparam int BASE_W     = 10;
    localparam int TGT_W      = 4;
    localparam int NOTE_W     = 7;
    localparam int DEV_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    localparam int IDX_W     = $clog2(NUM_NOTES);
    localparam int LAST_NOTE = NUM_NOTES - 1;

    localparam int RATIO_INT_W = ((NUM_NOTES - 1) / 12 >= 4) ? (NUM_NOTES - 1) / 12 - 3 : 1;
    localparam int RATIO_W     = RATIO_FRAC_BITS + RATIO_INT_W;
    localparam int PROD_W      = BASE_W + RATIO_W;
    localparam int X_W         = IN_W + RATIO_FRAC_BITS - 8;
    localparam int F_W         = (PROD_W > X_W) ? PROD_W : X_W;
    localparam int Q_W         = 8;
    localparam int QCNT_W      = 3;
    localparam int NUM_W       = F_W + Q_W;

    localparam int BASE_RESET = 440;
    localparam int DEV_MAX    = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(1);

    localparam logic [TGT_W-1:0] TGT_FREE      = TGT_W'(0);
    localparam logic [TGT_W-1:0] TGT_CELLO_A3  = TGT_W'(1);
    localparam logic [TGT_W-1:0] TGT_CELLO_D3  = TGT_W'(2);
    localparam logic [TGT_W-1:0] TGT_CELLO_G2  = TGT_W'(3);
    localparam logic [TGT_W-1:0] TGT_CELLO_C2  = TGT_W'(4);
    localparam logic [TGT_W-1:0] TGT_GUITAR_E4 = TGT_W'(5);
    localparam logic [TGT_W-1:0] TGT_GUITAR_B3 = TGT_W'(6);
    localparam logic [TGT_W-1:0] TGT_GUITAR_G3 = TGT_W'(7);
    localparam logic [TGT_W-1:0] TGT_GUITAR_D3 = TGT_W'(8);
    localparam logic [TGT_W-1:0] TGT_GUITAR_A2 = TGT_W'(9);
    localparam logic [TGT_W-1:0] TGT_GUITAR_E2 = TGT_W'(10);

    // 2^(k/12) in Q1.32, rounded
    localparam logic [32:0] SEMI_ROM [12] = '{
        33'd4294967296, 33'd4550359342, 33'd4820937788, 33'd5107605667,
        33'd5411319705, 33'd5733093519, 33'd6074001000, 33'd6435179895,
        33'd6817835604, 33'd7223245206, 33'd7652761717, 33'd8107818609
    };

    typedef logic [RATIO_W-1:0] t_ratio_tab [NUM_NOTES];

    // ratio of note i to A4, rounded half up to RATIO_FRAC_BITS fraction bits
    function automatic t_ratio_tab build_ratio_tab();
        t_ratio_tab  tab;
        logic [63:0] m;
        logic [63:0] r;
        int          sh;
        for (int i = 0; i < NUM_NOTES; i++) begin
            m  = 64'(SEMI_ROM[i % 12]);
            sh = SEMI_FRAC_BITS + REF_OCTAVES - RATIO_FRAC_BITS - i / 12;
            if (sh > 0) begin
                r = (m + (64'd1 << (sh - 1))) >> sh;
            end else begin
                r = m << (-sh);
            end
            tab[i] = r[RATIO_W-1:0];
        end
        return tab;
    endfunction

    localparam t_ratio_tab RATIO_TAB = build_ratio_tab();

    typedef struct packed {
        logic load;
        logic srch;
        logic fmul;
        logic cmp;
        logic nmul;
        logic spc;
        logic chk;
        logic div;
        logic store;
    } t_cmd;

    typedef struct packed {
        logic free;
        logic srch_done;
        logic div_done;
    } t_stat;

endpackage

// ===== rtl/tuner_note_deviation.sv =====
// ----------------------------------------------------------------------------
// tuner_note_deviation
// Equal-tempered tuner: nearest or fixed string note and percent deviation.
// ----------------------------------------------------------------------------
// One item at a time. In free mode the search runs one note per cycle
// through the single base-times-ratio multiplier and ends with the compare
// of the last note; then follow the target frequency, offset, neighbor
// frequency, spacing and range check, the restoring divider, and the load
// of the output register.
// A string target skips the search. The next item is accepted once the
// previous one sits in the output register; a result that is not taken
// holds the following item at the output stage.
module tuner_note_deviation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tnd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tnd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [tnd_pkg::IN_W-1:0]              i_detected_freq,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [tnd_pkg::NOTE_W-1:0]            o_note_index,
    output logic signed [tnd_pkg::DEV_W-1:0]      o_deviation
);

    logic [tnd_pkg::BASE_W-1:0] r_base;
    logic [tnd_pkg::TGT_W-1:0]  r_target;
    logic [tnd_pkg::BASE_W-1:0] w_base_eff;
    tnd_pkg::t_cmd              w_cmd;
    tnd_pkg::t_stat             w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= tnd_pkg::BASE_W'(tnd_pkg::BASE_RESET);
            r_target <= tnd_pkg::TGT_FREE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tnd_pkg::CFG_BASE:   r_base   <= i_cfg_data[tnd_pkg::BASE_W-1:0];
                tnd_pkg::CFG_TARGET: r_target <= i_cfg_data[tnd_pkg::TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero base acts as 1 Hz
    assign w_base_eff = (r_base == '0) ? tnd_pkg::BASE_W'(1) : r_base;

    tnd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tnd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_base          (w_base_eff),
        .i_target        (r_target),
        .i_detected_freq (i_detected_freq),
        .o_note_index    (o_note_index),
        .o_deviation     (o_deviation)
    );

endmodule

// ===== rtl/tnd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnd_ctrl
// Sequencer of the note tuner: search, neighbor fetch, divide, output.
// ----------------------------------------------------------------------------
module tnd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tnd_pkg::t_stat i_stat,
    output tnd_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRCH = 4'd1;
    localparam logic [3:0] ST_FMUL = 4'd2;
    localparam logic [3:0] ST_CMP  = 4'd3;
    localparam logic [3:0] ST_NMUL = 4'd4;
    localparam logic [3:0] ST_SPC  = 4'd5;
    localparam logic [3:0] ST_CHK  = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.free ? ST_SRCH : ST_FMUL;
                end
            end
            ST_SRCH: begin
                o_cmd.srch = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = ST_FMUL;
                end
            end
            ST_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_NMUL;
            end
            ST_NMUL: begin
                o_cmd.nmul = 1'b1;
                n_state    = ST_SPC;
            end
            ST_SPC: begin
                o_cmd.spc = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.store = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/tnd_dp.sv =====
// ----------------------------------------------------------------------------
// tnd_dp
// Datapath of the note tuner: note frequency multiplier, nearest note
// search, spacing and a restoring divider for the percent deviation.
// ----------------------------------------------------------------------------
module tnd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tnd_pkg::t_cmd                       i_cmd,
    output tnd_pkg::t_stat                      o_stat,
    input  logic [tnd_pkg::BASE_W-1:0]          i_base,
    input  logic [tnd_pkg::TGT_W-1:0]           i_target,
    input  logic [tnd_pkg::IN_W-1:0]            i_detected_freq,
    output logic [tnd_pkg::NOTE_W-1:0]          o_note_index,
    output logic signed [tnd_pkg::DEV_W-1:0]    o_deviation
);

    localparam int IDX_W  = tnd_pkg::IDX_W;
    localparam int F_W    = tnd_pkg::F_W;
    localparam int NUM_W  = tnd_pkg::NUM_W;
    localparam int Q_W    = tnd_pkg::Q_W;
    localparam int PROD_W = tnd_pkg::PROD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(tnd_pkg::LAST_NOTE);

    function automatic logic [IDX_W-1:0] string_note(input logic [tnd_pkg::TGT_W-1:0] t);
        logic [7:0] n;
        unique case (t)
            tnd_pkg::TGT_CELLO_A3:  n = 8'd36;
            tnd_pkg::TGT_CELLO_D3:  n = 8'd29;
            tnd_pkg::TGT_CELLO_G2:  n = 8'd22;
            tnd_pkg::TGT_CELLO_C2:  n = 8'd15;
            tnd_pkg::TGT_GUITAR_E4: n = 8'd43;
            tnd_pkg::TGT_GUITAR_B3: n = 8'd38;
            tnd_pkg::TGT_GUITAR_G3: n = 8'd34;
            tnd_pkg::TGT_GUITAR_D3: n = 8'd29;
            tnd_pkg::TGT_GUITAR_A2: n = 8'd24;
            tnd_pkg::TGT_GUITAR_E2: n = 8'd19;
            default:                n = 8'd0;
        endcase
        if (n > 8'(tnd_pkg::LAST_NOTE)) begin
            n = 8'(tnd_pkg::LAST_NOTE);
        end
        return n[IDX_W-1:0];
    endfunction

    logic [F_W-1:0]    r_x;
    logic [IDX_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_fidx;
    logic              r_fv;
    logic [F_W-1:0]    r_f;
    logic [F_W-1:0]    r_g;
    logic [F_W-1:0]    r_best;
    logic [IDX_W-1:0]  r_idx;
    logic              r_ge;
    logic              r_up;
    logic [F_W-1:0]    r_diff;
    logic [F_W-1:0]    r_spc;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_q;
    logic [tnd_pkg::QCNT_W-1:0] r_dcnt;
    logic              r_big;
    logic [tnd_pkg::NOTE_W-1:0] r_note;
    logic [tnd_pkg::DEV_W-1:0]  r_dev;

    logic [IDX_W-1:0]  w_msel;
    logic [IDX_W-1:0]  w_nidx;
    logic              w_up;
    logic [PROD_W-1:0] w_prod;
    logic              w_xge;
    logic [F_W-1:0]    w_absd;
    logic [NUM_W-1:0]  w_dsub;
    logic              w_dge;
    logic [Q_W-1:0]    w_mag;

    assign w_up   = (r_idx == '0) || (r_ge && (r_idx != LAST_IDX));
    assign w_nidx = w_up ? r_idx + IDX_W'(1) : r_idx - IDX_W'(1);

    always_comb begin
        if (i_cmd.srch) begin
            w_msel = r_cnt;
        end else if (i_cmd.nmul) begin
            w_msel = w_nidx;
        end else begin
            w_msel = r_idx;
        end
    end

    // base times ratio, exact, in units of 2^-RATIO_FRAC_BITS Hz
    assign w_prod = PROD_W'(i_base) * PROD_W'(tnd_pkg::RATIO_TAB[w_msel]);

    assign w_xge  = (r_x >= r_f);
    assign w_absd = w_xge ? r_x - r_f : r_f - r_x;

    assign w_dsub = NUM_W'(r_spc) << r_dcnt;
    assign w_dge  = (r_rem >= w_dsub);

    assign w_mag = (r_big || (r_q > Q_W'(tnd_pkg::DEV_MAX))) ? Q_W'(tnd_pkg::DEV_MAX) : r_q;

    assign o_stat.free      = (i_target == tnd_pkg::TGT_FREE) ||
                              (i_target > tnd_pkg::TGT_GUITAR_E2);
    assign o_stat.srch_done = r_fv && (r_fidx == LAST_IDX);
    assign o_stat.div_done  = (r_dcnt == '0);

    assign o_note_index = r_note;
    assign o_deviation  = r_dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_cmd.load) begin
            r_fv <= 1'b0;
        end else if (i_cmd.srch) begin
            r_fv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= F_W'(i_detected_freq) << (tnd_pkg::RATIO_FRAC_BITS - 8);
            r_cnt <= '0;
            r_idx <= string_note(i_target);
        end
        if (i_cmd.srch) begin
            r_f    <= F_W'(w_prod);
            r_fidx <= r_cnt;
            if (r_cnt != LAST_IDX) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            // strict compare: lower note wins a tie
            if (r_fv && ((r_fidx == '0) || (w_absd < r_best))) begin
                r_best <= w_absd;
                r_idx  <= r_fidx;
            end
        end
        if (i_cmd.fmul) begin
            r_f <= F_W'(w_prod);
        end
        if (i_cmd.cmp) begin
            r_ge   <= w_xge;
            r_diff <= w_absd;
        end
        if (i_cmd.nmul) begin
            r_g  <= F_W'(w_prod);
            r_up <= w_up;
        end
        if (i_cmd.spc) begin
            r_spc <= r_up ? r_g - r_f : r_f - r_g;
            // 200 * diff
            r_num <= (NUM_W'(r_diff) << 7) + (NUM_W'(r_diff) << 6) + (NUM_W'(r_diff) << 3);
        end
        if (i_cmd.chk) begin
            r_big  <= (!r_ge && (r_idx == '0)) || (r_diff >= r_spc);
            r_rem  <= r_num;
            r_q    <= '0;
            r_dcnt <= '1;
        end
        if (i_cmd.div) begin
            if (w_dge) begin
                r_rem <= r_rem - w_dsub;
            end
            r_q    <= {r_q[Q_W-2:0], w_dge};
            r_dcnt <= r_dcnt - tnd_pkg::QCNT_W'(1);
        end
        if (i_cmd.store) begin
            r_note <= tnd_pkg::NOTE_W'(r_idx);
            r_dev  <= r_ge ? w_mag : -w_mag;
        end
    end

endmodule

// ===== rtl/tnd_checker.sv =====
// ----------------------------------------------------------------------------
// tnd_checker
// Port-level checks of the note tuner, bound to the top level.
// ----------------------------------------------------------------------------
module tnd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [tnd_pkg::NOTE_W-1:0]         o_note_index,
    input logic signed [tnd_pkg::DEV_W-1:0]   o_deviation
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_note_index) && $stable(o_deviation))
        else $error("result changed while stalled");

    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_deviation <= 8'sd100) && (o_deviation >= -8'sd100))
        else $error("deviation out of range");

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_note_index <= tnd_pkg::NOTE_W'(tnd_pkg::LAST_NOTE)))
        else $error("note index beyond scale");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

endmodule

bind tuner_note_deviation tnd_checker u_tnd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_note_index (o_note_index),
    .o_deviation  (o_deviation)
);
